@@ src/pp20_pkg.sv @@
// ----------------------------------------------------------------------------
// pp20_pkg
// Types and constants shared by the backward LZ decoder modules.
// ----------------------------------------------------------------------------
package pp20_pkg;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_WIDTH0 = 3'd0;
    localparam logic [2:0] REG_WIDTH1 = 3'd1;
    localparam logic [2:0] REG_WIDTH2 = 3'd2;
    localparam logic [2:0] REG_WIDTH3 = 3'd3;
    localparam logic [2:0] REG_SKIP   = 3'd4;
    localparam logic [2:0] REG_ULEN   = 3'd5;

    // Reset values of the registers
    localparam logic [3:0]  RST_WIDTH0 = 4'd9;
    localparam logic [3:0]  RST_WIDTH1 = 4'd10;
    localparam logic [3:0]  RST_WIDTH2 = 4'd11;
    localparam logic [3:0]  RST_WIDTH3 = 4'd11;
    localparam logic [5:0]  RST_SKIP   = 6'd0;
    localparam logic [23:0] RST_ULEN   = 24'd1;

    // Error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_UNNEEDED = 2'd1;
    localparam logic [1:0] ERR_RANGE    = 2'd2;
    localparam logic [1:0] ERR_OVERRUN  = 2'd3;

    // Stream grammar constants
    localparam logic [1:0]  LITLEN_ESC     = 2'd3;
    localparam logic [2:0]  COPYLEN_ESC    = 3'd7;
    localparam logic [1:0]  LONG_IDX       = 2'd3;
    localparam logic [5:0]  SHORT_OFS_BITS = 6'd7;
    localparam logic [23:0] LONG_COPY_BASE = 24'd5;
    localparam logic [23:0] MAX24          = 24'hFFFFFF;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] packed_byte;
    } t_in_item;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic [23:0] out_position;
        logic        last_of_run;
        logic        need_byte;
        logic        finished;
        logic [1:0]  error_code;
    } t_out_item;

    typedef struct packed {
        logic [3:0][3:0] wfi;
        logic [5:0]      skip;
        logic [23:0]     ulen;
    } t_cfg;

    typedef struct packed {
        logic        go;
        logic [5:0]  skip;
        logic [23:0] ulen;
    } t_restart;

    typedef struct packed {
        logic accept;
        logic step;
        logic copy_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic stop;
        logic copy_rd;
    } t_dp_sts;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        logic [23:0] pos;
    } t_push;

    typedef struct packed {
        logic       need_byte;
        logic       finished;
        logic [1:0] code;
    } t_status;

    typedef struct packed {
        logic clr;
        logic ld;
    } t_ob_cmd;

    typedef struct packed {
        logic full;
        logic last;
        logic out_free;
    } t_ob_sts;

endpackage

@@ src/pp20_dp.sv @@
// ----------------------------------------------------------------------------
// pp20_dp
// Decode datapath: bit reader, field parser, history window and copy engine.
// ----------------------------------------------------------------------------
module pp20_dp #(
    parameter int WINDOW_DEPTH = 32768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pp20_pkg::t_cfg     i_cfg,
    input  pp20_pkg::t_restart i_restart,
    input  pp20_pkg::t_dp_cmd  i_cmd,
    input  pp20_pkg::t_in_item i_item,
    output pp20_pkg::t_dp_sts  o_sts,
    output pp20_pkg::t_push    o_push,
    output pp20_pkg::t_status  o_status
);
    import pp20_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    typedef enum logic [3:0] {
        PH_SKIP, PH_FLAG, PH_LITLEN, PH_LITBYTE, PH_IDX, PH_SHORT,
        PH_OFFSET, PH_COPYLEN, PH_COPY, PH_DONE, PH_ERR_RANGE, PH_ERR_OVER
    } t_phase;

    t_phase      r_ph, n_ph;
    logic [7:0]  r_buf, n_buf;
    logic [3:0]  r_bl, n_bl;
    logic [14:0] r_acc, n_acc;
    logic [5:0]  r_need, n_need;
    logic [23:0] r_run, n_run;
    logic [1:0]  r_li, n_li;
    logic [14:0] r_dist, n_dist;
    logic [23:0] r_wp, n_wp;
    logic        r_unneeded, n_unneeded;

    logic [7:0]  r_win [2**AW];
    logic [7:0]  r_rdata;

    logic        bitph, has_bit, starve, range_bad;
    logic [24:0] src;
    logic [AW-1:0] rd_addr;
    logic [14:0] acc_t;
    logic [5:0]  need_t;
    logic [24:0] sum;
    logic        do_emit, emit_lit;
    logic [7:0]  e_data;
    logic [23:0] wp_new, run_new;

    function automatic logic [23:0] sat24(input logic [24:0] s);
        return (s > {1'b0, MAX24}) ? MAX24 : s[23:0];
    endfunction

    always_comb begin
        n_ph       = r_ph;
        n_buf      = r_buf;
        n_bl       = r_bl;
        n_acc      = r_acc;
        n_need     = r_need;
        n_run      = r_run;
        n_li       = r_li;
        n_dist     = r_dist;
        n_wp       = r_wp;
        n_unneeded = r_unneeded;
        o_sts      = '0;
        o_push     = '0;
        acc_t      = r_acc;
        need_t     = r_need;
        sum        = '0;
        do_emit    = 1'b0;
        emit_lit   = 1'b0;
        e_data     = '0;
        wp_new     = r_wp - 24'd1;
        run_new    = r_run - 24'd1;

        bitph     = (r_ph <= PH_COPYLEN);
        has_bit   = (r_need != 6'd0);
        starve    = has_bit && (r_bl == 4'd0);
        src       = {1'b0, r_wp} + {10'b0, r_dist};
        range_bad = (src >= {1'b0, i_cfg.ulen}) ||
                    ({17'b0, r_dist} >= 32'(WINDOW_DEPTH));
        rd_addr   = src[AW-1:0];

        o_sts.stop = (r_ph != PH_COPY) && !(bitph && !starve);

        if (i_cmd.accept) begin
            n_unneeded = 1'b0;
            if (!i_item.is_tick) begin
                if (bitph && r_bl == 4'd0) begin
                    n_buf = i_item.packed_byte;
                    n_bl  = 4'd8;
                end else begin
                    n_unneeded = 1'b1;
                end
            end
        end

        if (i_cmd.step) begin
            if (r_ph == PH_COPY) begin
                if (range_bad) begin
                    n_ph = PH_ERR_RANGE;
                end else begin
                    o_sts.copy_rd = 1'b1;
                end
            end else if (bitph && !starve) begin
                if (has_bit) begin
                    acc_t  = {r_acc[13:0], r_buf[0]};
                    need_t = r_need - 6'd1;
                    n_buf  = r_buf >> 1;
                    n_bl   = r_bl - 4'd1;
                    n_acc  = acc_t;
                    n_need = need_t;
                end
                if (need_t == 6'd0) begin
                    unique case (r_ph)
                        PH_SKIP: begin
                            n_ph = PH_FLAG; n_need = 6'd1; n_acc = '0;
                        end
                        PH_FLAG: begin
                            n_acc = '0;
                            if (!acc_t[0]) begin
                                n_run = '0; n_ph = PH_LITLEN; n_need = 6'd2;
                            end else begin
                                n_ph = PH_IDX; n_need = 6'd2;
                            end
                        end
                        PH_LITLEN: begin
                            sum = {1'b0, r_run} + 25'(acc_t[1:0])
                                + 25'(acc_t[1:0] != LITLEN_ESC);
                            n_run = sat24(sum);
                            n_acc = '0;
                            if (acc_t[1:0] == LITLEN_ESC) begin
                                n_ph = PH_LITLEN; n_need = 6'd2;
                            end else begin
                                n_ph = PH_LITBYTE; n_need = 6'd8;
                            end
                        end
                        PH_LITBYTE: begin
                            do_emit  = 1'b1;
                            emit_lit = 1'b1;
                            e_data   = acc_t[7:0];
                        end
                        PH_IDX: begin
                            n_li  = acc_t[1:0];
                            n_acc = '0;
                            if (acc_t[1:0] == LONG_IDX) begin
                                n_ph = PH_SHORT; n_need = 6'd1;
                            end else begin
                                n_run  = 24'(acc_t[1:0]) + 24'd2;
                                n_ph   = PH_OFFSET;
                                n_need = {2'b0, i_cfg.wfi[acc_t[1:0]]};
                            end
                        end
                        PH_SHORT: begin
                            n_run  = LONG_COPY_BASE;
                            n_acc  = '0;
                            n_ph   = PH_OFFSET;
                            n_need = acc_t[0] ? {2'b0, i_cfg.wfi[LONG_IDX]}
                                              : SHORT_OFS_BITS;
                        end
                        PH_OFFSET: begin
                            n_dist = acc_t;
                            if (r_li == LONG_IDX) begin
                                n_ph = PH_COPYLEN; n_need = 6'd3; n_acc = '0;
                            end else begin
                                n_ph = PH_COPY;
                            end
                        end
                        PH_COPYLEN: begin
                            sum   = {1'b0, r_run} + 25'(acc_t[2:0]);
                            n_run = sat24(sum);
                            if (acc_t[2:0] == COPYLEN_ESC) begin
                                n_ph = PH_COPYLEN; n_need = 6'd3; n_acc = '0;
                            end else begin
                                n_ph = PH_COPY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end

        if (i_cmd.copy_emit) begin
            do_emit = 1'b1;
            e_data  = r_rdata;
        end

        if (do_emit) begin
            if (r_wp == 24'd0) begin
                n_ph = PH_ERR_OVER;
            end else begin
                n_wp        = wp_new;
                n_run       = run_new;
                o_push.valid = 1'b1;
                o_push.data  = e_data;
                o_push.pos   = wp_new;
                if (emit_lit) begin
                    n_acc = '0;
                    if (run_new != 24'd0) begin
                        n_ph = PH_LITBYTE; n_need = 6'd8;
                    end else begin
                        n_ph = PH_IDX; n_need = 6'd2;
                    end
                end else if (run_new == 24'd0) begin
                    n_ph = PH_FLAG; n_need = 6'd1; n_acc = '0;
                end
                if (run_new == 24'd0 && wp_new == 24'd0) begin
                    n_ph = PH_DONE;
                end
            end
        end

        o_status.need_byte = bitph && (r_bl == 4'd0);
        o_status.finished  = (r_ph == PH_DONE);
        if (r_ph == PH_ERR_RANGE) begin
            o_status.code = ERR_RANGE;
        end else if (r_ph == PH_ERR_OVER) begin
            o_status.code = ERR_OVERRUN;
        end else begin
            o_status.code = r_unneeded ? ERR_UNNEEDED : ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart.go) begin
            r_ph   <= PH_SKIP;
            r_buf  <= '0;
            r_bl   <= '0;
            r_acc  <= '0;
            r_run  <= '0;
            r_li   <= '0;
            r_dist <= '0;
            r_need <= i_rst_n ? i_restart.skip : RST_SKIP;
            r_wp   <= i_rst_n ? i_restart.ulen : RST_ULEN;
        end else begin
            r_ph   <= n_ph;
            r_buf  <= n_buf;
            r_bl   <= n_bl;
            r_acc  <= n_acc;
            r_need <= n_need;
            r_run  <= n_run;
            r_li   <= n_li;
            r_dist <= n_dist;
            r_wp   <= n_wp;
        end
        if (!i_rst_n) begin
            r_unneeded <= 1'b0;
        end else begin
            r_unneeded <= n_unneeded;
        end
    end

    // History window: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (o_push.valid) begin
            r_win[wp_new[AW-1:0]] <= o_push.data;
        end
        r_rdata <= r_win[rd_addr];
    end

endmodule

@@ src/pp20_obuf.sv @@
// ----------------------------------------------------------------------------
// pp20_obuf
// Result buffer for one item and the output register that drains it.
// ----------------------------------------------------------------------------
module pp20_obuf #(
    parameter int RESULTS_PER_ITEM = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pp20_pkg::t_ob_cmd   i_cmd,
    input  pp20_pkg::t_push     i_push,
    input  pp20_pkg::t_status   i_status,
    input  logic                i_out_stall,
    output pp20_pkg::t_ob_sts   o_sts,
    output logic                o_out_valid,
    output pp20_pkg::t_out_item o_out_item
);
    import pp20_pkg::*;

    localparam int CW  = $clog2(RESULTS_PER_ITEM + 1);
    localparam int RAW = (RESULTS_PER_ITEM > 1) ? $clog2(RESULTS_PER_ITEM) : 1;

    logic [31:0]    r_mem [RESULTS_PER_ITEM];
    logic [31:0]    r_rd;
    logic [CW-1:0]  r_cnt;
    logic [RAW-1:0] r_ridx;
    logic           r_ov;
    t_out_item      r_out;

    assign o_sts.full     = (r_cnt == CW'(RESULTS_PER_ITEM));
    assign o_sts.last     = ((CW'(r_ridx) + CW'(1)) >= r_cnt);
    assign o_sts.out_free = !r_ov || !i_out_stall;
    assign o_out_valid    = r_ov;
    assign o_out_item     = r_out;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_cnt[RAW-1:0]] <= {i_push.data, i_push.pos};
        end
        r_rd <= r_mem[r_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ridx <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_cnt  <= '0;
                r_ridx <= '0;
            end else if (i_push.valid) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.ld) begin
                r_ov <= 1'b1;
                if (!o_sts.last) begin
                    r_ridx <= r_ridx + RAW'(1);
                end
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Item with no byte gives a single empty result
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_out.byte_valid   <= (r_cnt != '0);
            r_out.out_byte     <= (r_cnt != '0) ? r_rd[31:24] : 8'd0;
            r_out.out_position <= (r_cnt != '0) ? r_rd[23:0] : 24'd0;
            r_out.last_of_run  <= o_sts.last;
            r_out.need_byte    <= i_status.need_byte;
            r_out.finished     <= i_status.finished;
            r_out.error_code   <= i_status.code;
        end
    end

endmodule

@@ src/pp20_ctrl.sv @@
// ----------------------------------------------------------------------------
// pp20_ctrl
// Item sequencer: accept, decode steps, copy read/write, result drain.
// ----------------------------------------------------------------------------
module pp20_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pp20_pkg::t_dp_sts i_dp_sts,
    input  pp20_pkg::t_ob_sts i_ob_sts,
    output logic              o_in_stall,
    output pp20_pkg::t_dp_cmd o_dp_cmd,
    output pp20_pkg::t_ob_cmd o_ob_cmd
);
    import pp20_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_COPY, S_DRN_RD, S_DRN_LD
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        o_ob_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_dp_cmd.accept = 1'b1;
                    o_ob_cmd.clr    = 1'b1;
                    n_state         = S_RUN;
                end
            end
            S_RUN: begin
                if (i_ob_sts.full || i_dp_sts.stop) begin
                    n_state = S_DRN_RD;
                end else begin
                    o_dp_cmd.step = 1'b1;
                    if (i_dp_sts.copy_rd) begin
                        n_state = S_COPY;
                    end
                end
            end
            S_COPY: begin
                o_dp_cmd.copy_emit = 1'b1;
                n_state            = S_RUN;
            end
            S_DRN_RD: begin
                n_state = S_DRN_LD;
            end
            S_DRN_LD: begin
                // hold until the output register frees up
                if (i_ob_sts.out_free) begin
                    o_ob_cmd.ld = 1'b1;
                    n_state     = i_ob_sts.last ? S_IDLE : S_DRN_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/pp20_backward_lz_decoder_top.sv @@
// ----------------------------------------------------------------------------
// pp20_backward_lz_decoder_top
// Backward LZ decoder for packed bodies fed from their last byte down.
// ----------------------------------------------------------------------------
// Input channel: one item per handshake, either a packed byte or a tick
// (is_tick) that lets a pending copy continue. o_in_stall is low only while
// the block is idle; the block works on one item at a time.
// Each item is parsed one stream bit per cycle by the field parser while the
// result buffer has room; a copied byte is a window read, then a write-back.
// All results of the item (at most RESULTS_PER_ITEM) are collected in a
// result buffer and then drained one at a time (buffer read, then output
// register load), so the status fields reflect the end of the item.
// Output channel: the last result sits in an output register while the next
// item is already accepted; when the receiver stalls, the drain holds.
// Reset: registers return to their defaults and decoding restarts at
// position unpacked_length; writing skip_bit_count or unpacked_length also
// restarts. The history window needs no clearing pass.
// ----------------------------------------------------------------------------
module pp20_backward_lz_decoder_top #(
    parameter int WINDOW_DEPTH     = 32768,
    parameter int RESULTS_PER_ITEM = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pp20_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output pp20_pkg::t_out_item o_out_item,
    input  logic                i_out_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pp20_pkg::*;

    t_cfg      r_cfg;
    t_restart  restart;
    t_dp_cmd   dp_cmd;
    t_dp_sts   dp_sts;
    t_push     push;
    t_status   status;
    t_ob_cmd   ob_cmd;
    t_ob_sts   ob_sts;
    logic      wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    assign restart.go   = wr && (idx == REG_SKIP || idx == REG_ULEN);
    assign restart.skip = (idx == REG_SKIP) ? pwdata[5:0] : r_cfg.skip;
    assign restart.ulen = (idx == REG_ULEN) ? pwdata[23:0] : r_cfg.ulen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wfi  <= {RST_WIDTH3, RST_WIDTH2, RST_WIDTH1, RST_WIDTH0};
            r_cfg.skip <= RST_SKIP;
            r_cfg.ulen <= RST_ULEN;
        end else if (wr) begin
            case (idx)
                REG_WIDTH0: r_cfg.wfi[0] <= pwdata[3:0];
                REG_WIDTH1: r_cfg.wfi[1] <= pwdata[3:0];
                REG_WIDTH2: r_cfg.wfi[2] <= pwdata[3:0];
                REG_WIDTH3: r_cfg.wfi[3] <= pwdata[3:0];
                REG_SKIP:   r_cfg.skip   <= pwdata[5:0];
                REG_ULEN:   r_cfg.ulen   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WIDTH0: prdata = {28'b0, r_cfg.wfi[0]};
            REG_WIDTH1: prdata = {28'b0, r_cfg.wfi[1]};
            REG_WIDTH2: prdata = {28'b0, r_cfg.wfi[2]};
            REG_WIDTH3: prdata = {28'b0, r_cfg.wfi[3]};
            REG_SKIP:   prdata = {26'b0, r_cfg.skip};
            REG_ULEN:   prdata = {8'b0, r_cfg.ulen};
            default:    prdata = '0;
        endcase
    end

    pp20_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_dp_sts   (dp_sts),
        .i_ob_sts   (ob_sts),
        .o_in_stall (o_in_stall),
        .o_dp_cmd   (dp_cmd),
        .o_ob_cmd   (ob_cmd)
    );

    pp20_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (restart),
        .i_cmd     (dp_cmd),
        .i_item    (i_in_item),
        .o_sts     (dp_sts),
        .o_push    (push),
        .o_status  (status)
    );

    pp20_obuf #(
        .RESULTS_PER_ITEM (RESULTS_PER_ITEM)
    ) u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ob_cmd),
        .i_push      (push),
        .i_status    (status),
        .i_out_stall (i_out_stall),
        .o_sts       (ob_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // An empty result is always the only result of its item
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.byte_valid |-> o_out_item.last_of_run)
        else $error("empty result not marked last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.byte_valid |->
        o_out_item.out_byte == 8'd0 && o_out_item.out_position == 24'd0)
        else $error("empty result carries data");

    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.finished |->
        o_out_item.error_code != ERR_RANGE && o_out_item.error_code != ERR_OVERRUN)
        else $error("finished together with a halting error");

endmodule

@@ tb/pp20_backward_lz_decoder_top_test.sv @@
// ----------------------------------------------------------------------------
// pp20_backward_lz_decoder_top_test
// Self-checking bench for the backward LZ decoder. A queue of items, built
// phase by phase together with a bit-exact predictor of the decoder, feeds a
// clocked driver; a clocked monitor compares every output item field by field
// with the predicted one. Registers are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module pp20_backward_lz_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pp20_pkg::*;

    localparam int HIST_DEPTH = 32768;
    localparam int MAX_PER_ITEM = 64;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_PAUSE = 400;

    typedef enum logic [3:0] {
        DP_SKIP, DP_FLAG, DP_LITLEN, DP_LITBYTE, DP_IDX, DP_SHORT,
        DP_OFFSET, DP_COPYLEN, DP_COPY, DP_DONE, DP_ERR_RANGE, DP_ERR_OVER
    } t_dec_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_item    i_in_item;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pp20_backward_lz_decoder_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_item(i_in_item), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_item(o_out_item), .i_out_stall(i_out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    int unsigned ofs_width [4];
    int unsigned skip_bits;
    int unsigned unpacked_len;
    logic [7:0]  bit_buf;
    int unsigned buf_bits;
    t_dec_phase  phase;
    logic [14:0] field_acc;
    int unsigned field_need;
    int unsigned run_len;
    int unsigned len_idx;
    int unsigned match_dist;
    int unsigned wr_pos;
    logic [7:0]  history [HIST_DEPTH];

    t_out_item   item_results [$];
    t_in_item    pending_items [$];
    t_out_item   predicted_out [$];

    int  mismatches;
    int  idle_cycles;
    int  cycle_cnt;
    logic in_fire;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit is_bit_phase(t_dec_phase ph);
        return ph <= DP_COPYLEN;
    endfunction

    function automatic void start_field(t_dec_phase ph, int unsigned nbits);
        phase = ph;
        field_need = nbits & 63;
        field_acc = '0;
    endfunction

    function automatic void restart_decode();
        bit_buf = '0;
        buf_bits = 0;
        run_len = 0;
        len_idx = 0;
        match_dist = 0;
        wr_pos = unpacked_len;
        start_field(DP_SKIP, skip_bits);
    endfunction

    function automatic int unsigned sat24(int unsigned a, int unsigned b);
        return (a + b > MAX24) ? MAX24 : a + b;
    endfunction

    function automatic bit emit_byte(logic [7:0] v);
        t_out_item r;
        if (wr_pos == 0) begin
            phase = DP_ERR_OVER;
            return 1'b0;
        end
        wr_pos--;
        history[wr_pos % HIST_DEPTH] = v;
        r = '0;
        r.byte_valid = 1'b1;
        r.out_byte = v;
        r.out_position = wr_pos[23:0];
        item_results.push_back(r);
        return 1'b1;
    endfunction

    function automatic void end_of_block();
        if (wr_pos == 0) phase = DP_DONE;
    endfunction

    function automatic void field_done();
        int unsigned a;
        a = field_acc;
        case (phase)
            DP_SKIP: start_field(DP_FLAG, 1);
            DP_FLAG: begin
                if (a == 0) begin
                    run_len = 0;
                    start_field(DP_LITLEN, 2);
                end else begin
                    start_field(DP_IDX, 2);
                end
            end
            DP_LITLEN: begin
                run_len = sat24(run_len, a);
                if (a == LITLEN_ESC) begin
                    start_field(DP_LITLEN, 2);
                end else begin
                    run_len = sat24(run_len, 1);
                    start_field(DP_LITBYTE, 8);
                end
            end
            DP_LITBYTE: begin
                if (emit_byte(a[7:0])) begin
                    run_len--;
                    if (run_len != 0) begin
                        start_field(DP_LITBYTE, 8);
                    end else begin
                        start_field(DP_IDX, 2);
                        end_of_block();
                    end
                end
            end
            DP_IDX: begin
                len_idx = a & 3;
                if (len_idx == LONG_IDX) begin
                    start_field(DP_SHORT, 1);
                end else begin
                    run_len = len_idx + 2;
                    start_field(DP_OFFSET, ofs_width[len_idx]);
                end
            end
            DP_SHORT: begin
                run_len = LONG_COPY_BASE;
                start_field(DP_OFFSET, a == 0 ? SHORT_OFS_BITS : ofs_width[3]);
            end
            DP_OFFSET: begin
                match_dist = a & 16'h7FFF;
                if (len_idx == LONG_IDX) start_field(DP_COPYLEN, 3);
                else phase = DP_COPY;
            end
            DP_COPYLEN: begin
                run_len = sat24(run_len, a);
                if (a == COPYLEN_ESC) start_field(DP_COPYLEN, 3);
                else phase = DP_COPY;
            end
            default: ;
        endcase
    endfunction

    function automatic void copy_byte();
        int unsigned src;
        src = wr_pos + match_dist;
        if (src >= unpacked_len || match_dist + 1 > HIST_DEPTH) begin
            phase = DP_ERR_RANGE;
            return;
        end
        if (!emit_byte(history[src % HIST_DEPTH])) return;
        run_len--;
        if (run_len == 0) begin
            start_field(DP_FLAG, 1);
            end_of_block();
        end
    endfunction

    function automatic bit wants_byte();
        return is_bit_phase(phase) && buf_bits == 0;
    endfunction

    // run one item through the predictor and queue what it must produce
    function automatic void decode_item(t_in_item it);
        bit unneeded;
        logic [1:0] code;
        t_out_item r;
        unneeded = 1'b0;
        item_results.delete();
        if (!it.is_tick) begin
            if (wants_byte()) begin
                bit_buf = it.packed_byte;
                buf_bits = 8;
            end else begin
                unneeded = 1'b1;
            end
        end
        while (item_results.size() < MAX_PER_ITEM) begin
            if (phase == DP_COPY) begin
                copy_byte();
            end else if (is_bit_phase(phase)) begin
                if (field_need > 0) begin
                    if (buf_bits == 0) break;
                    field_acc = {field_acc[13:0], bit_buf[0]};
                    bit_buf = bit_buf >> 1;
                    buf_bits--;
                    field_need--;
                end
                if (field_need == 0) field_done();
            end else begin
                break;
            end
        end
        if (item_results.size() == 0) item_results.push_back('0);
        if (phase == DP_ERR_RANGE) code = ERR_RANGE;
        else if (phase == DP_ERR_OVER) code = ERR_OVERRUN;
        else code = unneeded ? ERR_UNNEEDED : ERR_OK;
        foreach (item_results[k]) begin
            r = item_results[k];
            r.last_of_run = (k == item_results.size() - 1);
            r.need_byte = wants_byte();
            r.finished = (phase == DP_DONE);
            r.error_code = code;
            predicted_out.push_back(r);
        end
    endfunction

    task automatic send_item(bit tick, logic [7:0] b);
        t_in_item it;
        it.is_tick = tick;
        it.packed_byte = b;
        decode_item(it);
        pending_items.push_back(it);
    endtask

    // mostly what the decoder asks for, some noise; stop shortly after the end
    task automatic send_stream(int n, bit hold_midway);
        int extra;
        extra = 0;
        for (int i = 0; i < n && extra < 2; i++) begin
            if (hold_midway && i == n / 2)
                wait (pending_items.size() == 0 && predicted_out.size() == 0);
            if (!is_bit_phase(phase) && phase != DP_COPY) extra++;
            if (wants_byte()) begin
                if ($urandom_range(99) < 92) send_item(1'b0, 8'($urandom));
                else send_item(1'b1, 8'($urandom));
            end else begin
                if ($urandom_range(99) < 88) send_item(1'b1, 8'($urandom));
                else send_item(1'b0, 8'($urandom));
            end
        end
    endtask

    task automatic settle();
        wait (pending_items.size() == 0 && predicted_out.size() == 0 && !i_in_valid);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, int unsigned value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx < REG_SKIP) begin
            ofs_width[idx] = value & 15;
        end else if (idx == REG_SKIP) begin
            skip_bits = value & 63;
            restart_decode();
        end else if (idx == REG_ULEN) begin
            unpacked_len = value & MAX24;
            restart_decode();
        end
    endtask

    task automatic set_widths(int unsigned w0, int unsigned w1, int unsigned w2,
                              int unsigned w3);
        reg_write(REG_WIDTH0, w0);
        reg_write(REG_WIDTH1, w1);
        reg_write(REG_WIDTH2, w2);
        reg_write(REG_WIDTH3, w3);
    endtask

    // driver: hold the item while stalled, advance after acceptance
    always @(posedge i_clk) in_fire <= i_in_valid && !o_in_stall;

    always @(negedge i_clk) begin
        bit calm;
        calm = cycle_cnt > 3000 && cycle_cnt < 6000;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
                i_in_item <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= !calm && $urandom_range(99) < 26;
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output item %p", o_out_item);
            end else begin
                e = predicted_out.pop_front();
                if (o_out_item.byte_valid !== e.byte_valid
                        || o_out_item.out_byte !== e.out_byte
                        || o_out_item.out_position !== e.out_position
                        || o_out_item.last_of_run !== e.last_of_run
                        || o_out_item.need_byte !== e.need_byte
                        || o_out_item.finished !== e.finished
                        || o_out_item.error_code !== e.error_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", e, o_out_item);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        cycle_cnt = 0;
        in_fire = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ofs_width[0] = RST_WIDTH0;
        ofs_width[1] = RST_WIDTH1;
        ofs_width[2] = RST_WIDTH2;
        ofs_width[3] = RST_WIDTH3;
        skip_bits = RST_SKIP;
        unpacked_len = RST_ULEN;
        restart_decode();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: one output byte; tick with nothing to do, then extra bytes
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'hA5);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h5A);
        settle();

        // zero length: the first literal overruns, later items stay halted
        reg_write(REG_ULEN, 0);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h00);
        settle();

        // widest offsets over the longest output, a skip of 32 bits
        set_widths(15, 15, 15, 15);
        reg_write(REG_SKIP, 32);
        reg_write(REG_ULEN, MAX24);
        for (int i = 0; i < 6; i++) send_item(1'b0, 8'($urandom));
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        settle();

        // one-bit offsets, no skip
        set_widths(1, 1, 1, 1);
        reg_write(REG_SKIP, 0);
        reg_write(REG_ULEN, 40);
        send_stream(10, 1'b0);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            if ($urandom_range(3) == 0)
                set_widths($urandom_range(1, 15), $urandom_range(1, 15),
                           $urandom_range(1, 15), $urandom_range(1, 15));
            else
                set_widths($urandom_range(1, 4), $urandom_range(1, 5),
                           $urandom_range(1, 6), $urandom_range(1, 6));
            reg_write(REG_SKIP, $urandom_range(0, 32));
            reg_write(REG_ULEN, $urandom_range(20, 250));
            send_stream(20, ph == 2);
            settle();
        end

        if (mismatches == 0 && predicted_out.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/pp20_pkg.sv
src/pp20_dp.sv
src/pp20_obuf.sv
src/pp20_ctrl.sv
src/pp20_backward_lz_decoder_top.sv
tb/pp20_backward_lz_decoder_top_test.sv
